@@ rtl/fsrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fsrc_pkg
// Shared types, constants and the Fibonacci term table for the Fibonacci
// sum representation counter.
// ----------------------------------------------------------------------------
package fsrc_pkg;

	// term table: 1, 2, 3, 5, 8, ... at indices 0..FIB_TERMS-1
	localparam int FIB_TERMS = 92;
	localparam int FIB_W     = 64;
	localparam int IDX_W     = $clog2(FIB_TERMS);

	// gap between chosen positions, up to FIB_TERMS
	localparam int GAP_W     = $clog2(FIB_TERMS + 1);

	// keep / split counters saturate at 2^40
	localparam int KS_W      = 41;
	localparam int PROD_W    = KS_W + GAP_W - 1;
	localparam logic [KS_W-1:0] INNER_CAP = KS_W'(64'h100_0000_0000);

	// result count saturates at 2^30
	localparam int COUNT_W   = 31;
	localparam int OUT_TDATA_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(32'h4000_0000);

	typedef logic [FIB_W-1:0] fib_table_t [FIB_TERMS];

	// built at elaboration, read as a constant table
	function automatic fib_table_t build_fib_table();
		fib_table_t t;
		t[0] = FIB_W'(1);
		t[1] = FIB_W'(2);
		for (int k = 2; k < FIB_TERMS; k++) begin
			t[k] = t[k-1] + t[k-2];
		end
		return t;
	endfunction

	localparam fib_table_t FIB_TABLE = build_fib_table();

	// clamp a wide count sum to the inner cap
	function automatic logic [KS_W-1:0] sat_inner(input logic [PROD_W:0] x);
		logic [KS_W-1:0] r;
		if (x > (PROD_W+1)'(INNER_CAP)) begin
			r = INNER_CAP;
		end else begin
			r = x[KS_W-1:0];
		end
		return r;
	endfunction

	// commands from the sequencer to the dp unit
	typedef struct packed {
		logic init;
		logic adv;
		logic chosen;
	} dp_cmd_t;

	// status back from the dp unit
	typedef struct packed {
		logic busy;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/fibonacci_sum_representation_count_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fibonacci_sum_representation_count_top
// Counts the sets of distinct Fibonacci numbers that add up to the input
// value: greedy Zeckendorf pass from the largest term, then a keep / split
// dynamic program over the chosen positions.
//
// channel   dir  beat contents
// s_axis    in   tdata[VALUE_BITS-1:0] value, zero padded to bytes
// m_axis    out  tdata[30:0] representation_count, bit 31 zero
//
// - one beat runs a greedy pass over all 92 term positions, one position a
//   cycle through the shared compare / subtract unit, then a dp pass over
//   the same positions through the keep and split multipliers, where a
//   chosen term stalls the dp pass for its add step
// - s_axis_tready is high only while no value is in work
// - a finished count waits in the output register; the next value is
//   accepted meanwhile, and its own result waits if that register is full
// - reset clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module fibonacci_sum_representation_count_top
	import fsrc_pkg::*;
#(
	parameter int VALUE_BITS = 60
)(
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,   // value
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [OUT_TDATA_W-1:0]                 m_axis_tdata    // representation_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GREEDY,
		ST_DP,
		ST_FINAL
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        k_q;
	logic [VALUE_BITS-1:0]   rem_q;
	logic [FIB_TERMS-1:0]    chosen_q;
	logic                    out_valid_q;
	logic [COUNT_W-1:0]      out_count_q;

	logic                    in_accept;
	logic [FIB_W-1:0]        term;
	logic [FIB_W-1:0]        rem_ext;
	logic                    take;
	dp_cmd_t                 dp_cmd;
	dp_stat_t                dp_stat;
	logic [KS_W-1:0]         keep;
	logic [KS_W-1:0]         split;
	logic [KS_W:0]           total;
	logic [COUNT_W-1:0]      total_sat;
	logic                    out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// greedy compare against the current term
	always_comb begin
		term    = FIB_TABLE[k_q];
		rem_ext = {{(FIB_W-VALUE_BITS){1'b0}}, rem_q};
		take    = (term <= rem_ext);
	end

	// dp unit control
	always_comb begin
		dp_cmd.init   = in_accept;
		dp_cmd.adv    = (state_q == ST_DP) && !dp_stat.busy;
		dp_cmd.chosen = chosen_q[0];
	end

	fsrc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dp_cmd),
		.stat   (dp_stat),
		.keep   (keep),
		.split  (split)
	);

	// final sum and saturation
	always_comb begin
		total = {1'b0, keep} + {1'b0, split};
		if (total > (KS_W+1)'(COUNT_CAP)) begin
			total_sat = COUNT_CAP;
		end else begin
			total_sat = total[COUNT_W-1:0];
		end
		out_load = (state_q == ST_FINAL) && !dp_stat.busy
			&& (!out_valid_q || m_axis_tready);
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			rem_q       <= '0;
			chosen_q    <= '0;
			out_valid_q <= 1'b0;
			out_count_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						rem_q   <= s_axis_tdata[VALUE_BITS-1:0];
						k_q     <= IDX_W'(FIB_TERMS - 1);
						state_q <= ST_GREEDY;
					end
				end
				ST_GREEDY: begin
					if (take) begin
						rem_q <= rem_q - term[VALUE_BITS-1:0];
					end
					chosen_q <= {chosen_q[FIB_TERMS-2:0], take};
					if (k_q == '0) begin
						state_q <= ST_DP;
					end else begin
						k_q <= k_q - IDX_W'(1);
					end
				end
				ST_DP: begin
					if (dp_cmd.adv) begin
						chosen_q <= chosen_q >> 1;
						if (k_q == IDX_W'(FIB_TERMS - 1)) begin
							state_q <= ST_FINAL;
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				ST_FINAL: begin
					if (out_load) begin
						out_count_q <= total_sat;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-COUNT_W){1'b0}}, out_count_q};

	// accepted beat starts the greedy pass at the top term
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ST_GREEDY) && (k_q == IDX_W'(FIB_TERMS - 1)))
		else $error("greedy pass did not start at the top term");

	// greedy decomposition always consumes the whole value
	a_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DP) |-> (rem_q == '0))
		else $error("greedy remainder not zero in dp pass");

	// dp unit only works while the sequencer drives it
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.busy |-> (state_q == ST_DP || state_q == ST_FINAL))
		else $error("dp unit busy outside dp pass");

	// a waiting result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_count_q)))
		else $error("pending result changed");

endmodule
`default_nettype wire

@@ rtl/fsrc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fsrc_dp
// Keep / split dynamic program over the chosen term positions, one position
// per advance; a chosen position takes a multiply beat and an add beat.
// ----------------------------------------------------------------------------
module fsrc_dp
	import fsrc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dp_cmd_t         cmd,
	output dp_stat_t             stat,
	output logic [KS_W-1:0]      keep,
	output logic [KS_W-1:0]      split
);

	logic [KS_W-1:0]   keep_q;
	logic [KS_W-1:0]   split_q;
	logic [GAP_W-1:0]  gap_q;
	logic              busy_q;
	logic [PROD_W-1:0] prod_keep_q;
	logic [PROD_W-1:0] prod_split_q;

	logic [GAP_W-1:0]  gap_next;
	logic [GAP_W-2:0]  fac_keep;
	logic [GAP_W-2:0]  fac_split;
	logic [PROD_W-1:0] prod_keep;
	logic [PROD_W-1:0] prod_split;

	// d = gap + 1; floor((d-1)/2) = gap/2, floor(d/2)
	always_comb begin
		gap_next   = gap_q + GAP_W'(1);
		fac_keep   = gap_q[GAP_W-1:1];
		fac_split  = gap_next[GAP_W-1:1];
		prod_keep  = PROD_W'(fac_keep) * PROD_W'(keep_q);
		prod_split = PROD_W'(fac_split) * PROD_W'(split_q);
	end

	// counters and gap tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q  <= KS_W'(1);
			split_q <= '0;
			gap_q   <= '0;
			busy_q  <= 1'b0;
		end else if (cmd.init) begin
			keep_q  <= KS_W'(1);
			split_q <= '0;
			gap_q   <= '0;
			busy_q  <= 1'b0;
		end else if (busy_q) begin
			keep_q  <= sat_inner((PROD_W+1)'(keep_q) + (PROD_W+1)'(split_q));
			split_q <= sat_inner((PROD_W+1)'(prod_keep_q) + (PROD_W+1)'(prod_split_q));
			gap_q   <= '0;
			busy_q  <= 1'b0;
		end else if (cmd.adv) begin
			if (cmd.chosen) begin
				busy_q <= 1'b1;
			end else begin
				gap_q <= gap_next;
			end
		end
	end

	// product registers
	always_ff @(posedge clk) begin
		if (!busy_q && cmd.adv && cmd.chosen) begin
			prod_keep_q  <= prod_keep;
			prod_split_q <= prod_split;
		end
	end

	assign stat.busy = busy_q;
	assign keep      = keep_q;
	assign split     = split_q;

endmodule
`default_nettype wire

@@ verif/tb_fibonacci_sum_representation_count_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_fibonacci_sum_representation_count_top
// Streams values into the Fibonacci sum representation counter and checks
// every count beat. A short directed table covers zero, the smallest values,
// the field and range extremes and ignored pad bits. It is followed by
// random values: plain, near Fibonacci terms, sparse term sums that give
// large counts, above 10^18, and with random pad bits. Expected counts come
// from a row's own count or an independent greedy decomposition and keep /
// split recount. Both sides idle at random between beats outside a burst.
// ----------------------------------------------------------------------------
module tb_fibonacci_sum_representation_count_top;
	import fsrc_pkg::*;

	localparam int          VALUE_BITS  = 60;
	localparam int          TDATA_IN_W  = ((VALUE_BITS + 7) / 8) * 8;
	localparam logic [63:0] VALUE_MASK  = (64'd1 << VALUE_BITS) - 64'd1;
	localparam logic [63:0] SPLIT_CAP   = 64'd1 << 40;
	localparam logic [63:0] COUNT_LIMIT = 64'd1073741824;
	localparam logic [63:0] RANGE_TOP   = 64'd1000000000000000000;
	localparam logic [63:0] ABOVE_SPAN  = 64'd152921504606846976;
	localparam int          RANDOM_ITEMS = 550;
	localparam int          DRAIN_CYCLES = 240;
	localparam int          BURST_LO     = 300;
	localparam int          BURST_HI     = 380;

	typedef struct {
		logic [63:0] value;
		bit          known;
		logic [30:0] count;
	} value_row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDATA_IN_W-1:0] s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	logic [63:0]  fib_term [FIB_TERMS];
	logic [30:0]  expected_counts [$];
	int           mismatch_count = 0;
	int           sent_count     = 0;
	int           received_count = 0;
	value_row_t   directed_rows [20];

	fibonacci_sum_representation_count_top #(
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// clock
	always #4 clk = ~clk;

	// term table 1, 2, 3, 5, 8, ...
	initial begin
		fib_term[0] = 64'd1;
		fib_term[1] = 64'd2;
		for (int k = 2; k < FIB_TERMS; k++) begin
			fib_term[k] = fib_term[k-1] + fib_term[k-2];
		end
	end

	// greedy decomposition, then keep / split recount over chosen positions
	function automatic logic [30:0] count_fib_sums(input logic [63:0] raw);
		logic [63:0] rest;
		logic [63:0] keep;
		logic [63:0] split;
		logic [63:0] nk;
		logic [63:0] ns;
		logic [63:0] gap;
		logic [63:0] last_pos;
		bit          picked [FIB_TERMS];
		rest     = raw & VALUE_MASK;
		keep     = 64'd1;
		split    = 64'd0;
		last_pos = 64'd0;
		for (int k = FIB_TERMS - 1; k >= 0; k--) begin
			picked[k] = 1'b0;
			if (fib_term[k] <= rest) begin
				picked[k] = 1'b1;
				rest      = rest - fib_term[k];
			end
		end
		for (int k = 0; k < FIB_TERMS; k++) begin
			if (picked[k]) begin
				gap = 64'(k + 1) - last_pos;
				nk  = keep + split;
				ns  = ((gap - 64'd1) / 64'd2) * keep + (gap / 64'd2) * split;
				if (nk > SPLIT_CAP) nk = SPLIT_CAP;
				if (ns > SPLIT_CAP) ns = SPLIT_CAP;
				keep     = nk;
				split    = ns;
				last_pos = 64'(k + 1);
			end
		end
		nk = keep + split;
		if (nk > COUNT_LIMIT) nk = COUNT_LIMIT;
		return nk[30:0];
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// one value beat; called at a falling edge, returns at a falling edge
	task automatic send_value(input logic [63:0] v, input bit known,
			input logic [30:0] typed_count, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v[TDATA_IN_W-1:0];
		do @(posedge clk); while (!s_axis_tready);
		expected_counts.push_back(known ? typed_count : count_fib_sums(v));
		sent_count++;
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		logic [63:0] v;
		logic [63:0] sum;
		int          mode;
		int          pos;
		int          step;
		int          fixed_step;
		int          gap;
		directed_rows = '{
			'{64'd0, 1'b1, 31'd1},
			'{64'd1, 1'b1, 31'd1},
			'{64'd2, 1'b1, 31'd1},
			'{64'd3, 1'b1, 31'd2},
			'{64'd4, 1'b1, 31'd1},
			'{64'd5, 1'b1, 31'd2},
			'{64'd6, 1'b0, 31'd0},
			'{64'd7, 1'b0, 31'd0},
			'{64'd100, 1'b0, 31'd0},
			'{64'd1000, 1'b0, 31'd0},
			'{RANGE_TOP - 64'd1, 1'b0, 31'd0},
			'{RANGE_TOP, 1'b0, 31'd0},
			'{RANGE_TOP + 64'd1, 1'b0, 31'd0},
			'{VALUE_MASK, 1'b0, 31'd0},
			'{64'h0AAA_AAAA_AAAA_AAAA, 1'b0, 31'd0},
			'{64'h0555_5555_5555_5555, 1'b0, 31'd0},
			'{64'h0000_0000_FFFF_FFFF, 1'b0, 31'd0},
			// pad bits above the value field are ignored
			'{64'hF000_0000_0000_0000, 1'b1, 31'd1},
			'{64'hF000_0000_0000_0003, 1'b1, 31'd2},
			'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 31'd0}
		};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			send_value(directed_rows[i].value, directed_rows[i].known,
				directed_rows[i].count, $urandom_range(0, 7));
		end

		// random values
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			mode = $urandom_range(0, 9);
			case (mode)
				0, 1: begin
					v = 64'($urandom_range(0, 1000));
				end
				2: begin
					v = {$urandom(), $urandom()} & VALUE_MASK;
				end
				3: begin
					v = fib_term[$urandom_range(0, 85)] - 64'd2 + 64'($urandom_range(0, 4));
					v = v & VALUE_MASK;
				end
				4, 5, 6, 7: begin
					// sparse term sums; fixed gaps of 3 or 4 push the count up
					fixed_step = (mode == 7) ? $urandom_range(3, 4) : 0;
					pos = $urandom_range(0, 5);
					sum = 64'd0;
					while (pos < FIB_TERMS && fib_term[pos] <= VALUE_MASK - sum) begin
						sum  = sum + fib_term[pos];
						step = (fixed_step != 0) ? fixed_step : $urandom_range(1, 6);
						pos  = pos + step;
						if (fixed_step == 0 && $urandom_range(0, 31) == 0) break;
					end
					v = sum;
				end
				8: begin
					v = RANGE_TOP + ({$urandom(), $urandom()} % ABOVE_SPAN);
				end
				default: begin
					v = {$urandom(), $urandom()};
				end
			endcase
			gap = (sent_count >= BURST_LO && sent_count < BURST_HI) ? 0 : $urandom_range(0, 7);
			send_value(v, 1'b0, 31'd0, gap);
		end
		s_axis_tvalid <= 1'b0;

		// drain
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// count beats against the oldest pending count
	initial begin
		int          stall;
		logic [31:0] want;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = (received_count >= BURST_LO && received_count < BURST_HI) ?
				0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			received_count++;
			if (expected_counts.size() == 0) begin
				report_mismatch($sformatf("count beat 0x%08h with none pending", m_axis_tdata));
			end else begin
				want = {1'b0, expected_counts.pop_front()};
				if (m_axis_tdata !== want) begin
					report_mismatch($sformatf("beat %0d: count %0d, want %0d",
						received_count - 1, m_axis_tdata, want));
				end
			end
			@(negedge clk);
		end
	end

	// watchdog
	initial begin
		#6000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
